[hw/rtl/json_string_unescape_utf8_core_assert.svh]
// Assertion macros for the unescaper RTL modules, used by jsu_burst.
`ifndef JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH
`define JSON_STRING_UNESCAPE_UTF8_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/jsu_pkg.sv]
// Shared types and constants of the JSON string unescaper.
package jsu_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

	typedef enum logic [3:0] {
		E_NONE        = 4'd0,
		E_NO_OPEN     = 4'd1,
		E_UNTERM      = 4'd2,
		E_END_ESC     = 4'd3,
		E_SHORT_U     = 4'd4,
		E_BAD_HEX     = 4'd5,
		E_MISSING_LOW = 4'd6,
		E_BAD_LOW     = 4'd7,
		E_LONE_LOW    = 4'd8,
		E_BAD_ESC     = 4'd9,
		E_CTRL_CHAR   = 4'd10
	} err_t;

	// Everything one input byte produces: up to four output bytes plus status.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nb;
		logic            done;
		err_t            err;
	} result_t;

endpackage

[hw/rtl/json_string_unescape_utf8_core.sv]
// Top level of the JSON string unescaper: input register, decoder and result register.
// Each text byte transfer is captured in an input register, decoded from that register
// and its results (zero to four UTF-8 bytes, with string_done or error_code on the last one)
// land in a result register that sends one item per output transfer. A byte enters every
// cycle as long as each byte yields at most one item and out_ready stays high; a byte that
// decodes to several items holds the input side while the result register drains, and a
// byte that yields no item is consumed without loading the result register.
module json_string_unescape_utf8_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       string_done,
	output logic [3:0] error_code,
	output logic       last
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;
	logic             free;
	logic             step;
	logic             emit;
	jsu_pkg::result_t res;

	assign step     = valid_s1 && free;
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			eot_s1  <= end_of_text;
		end
	end

	jsu_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.in_byte     (byte_s1),
		.end_of_text (eot_s1),
		.res         (res),
		.emit        (emit)
	);

	jsu_burst u_burst (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (step && emit),
		.res         (res),
		.free        (free),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.byte_valid  (byte_valid),
		.string_done (string_done),
		.error_code  (error_code),
		.last        (last)
	);

endmodule

[hw/rtl/jsu_decode.sv]
// Decoder state machine: consumes one text byte and yields its decoded bytes and status.
module jsu_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                end_of_text,
	output jsu_pkg::result_t    res,
	output logic                emit
);

	typedef enum logic [2:0] {
		M_START  = 3'd0,
		M_HUNT   = 3'd1,
		M_STR    = 3'd2,
		M_ESC    = 3'd3,
		M_HEX1   = 3'd4,
		M_NEEDBS = 3'd5,
		M_NEEDU  = 3'd6,
		M_HEX2   = 3'd7
	} mode_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      nb;
	} utf8_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_count_q, hex_count_d;
	logic [15:0] code_accum_q, code_accum_d;
	logic [15:0] high_q, high_d;

	logic [4:0]  hx;
	logic [15:0] acc_new;
	logic [20:0] cp;
	logic        enc;
	utf8_t       utf;

	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = '0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] c);
		utf8_t u;
		u = '0;
		if (c < 21'h80) begin
			u.bytes[0] = c[7:0];
			u.nb = 3'd1;
		end else if (c < 21'h800) begin
			u.bytes[0] = {3'b110, c[10:6]};
			u.bytes[1] = {2'b10, c[5:0]};
			u.nb = 3'd2;
		end else if (c < 21'h10000) begin
			u.bytes[0] = {4'b1110, c[15:12]};
			u.bytes[1] = {2'b10, c[11:6]};
			u.bytes[2] = {2'b10, c[5:0]};
			u.nb = 3'd3;
		end else begin
			u.bytes[0] = {5'b11110, c[20:18]};
			u.bytes[1] = {2'b10, c[17:12]};
			u.bytes[2] = {2'b10, c[11:6]};
			u.bytes[3] = {2'b10, c[5:0]};
			u.nb = 3'd4;
		end
		return u;
	endfunction

	assign hx      = hex_digit(in_byte);
	assign acc_new = {code_accum_q[11:0], hx[3:0]};
	assign utf     = utf8_encode(cp);

	always_comb begin
		mode_d      = mode_q;
		hex_count_d = hex_count_q;
		code_accum_d = code_accum_q;
		high_d      = high_q;
		res         = '0;
		res.err     = jsu_pkg::E_NONE;
		cp          = '0;
		enc         = 1'b0;

		unique case (mode_q)
			M_STR: begin
				if (in_byte == jsu_pkg::CH_QUOTE) res.done = 1'b1;
				else if (in_byte == jsu_pkg::CH_BSLASH) mode_d = M_ESC;
				else if (in_byte < jsu_pkg::CH_CTRL_LIMIT) res.err = jsu_pkg::E_CTRL_CHAR;
				else begin
					res.bytes[0] = in_byte;
					res.nb = 3'd1;
				end
			end
			M_ESC: begin
				mode_d = M_STR;
				res.nb = 3'd1;
				unique case (in_byte)
					8'h22: res.bytes[0] = 8'h22;
					8'h5C: res.bytes[0] = 8'h5C;
					8'h2F: res.bytes[0] = 8'h2F;
					8'h62: res.bytes[0] = 8'h08;
					8'h66: res.bytes[0] = 8'h0C;
					8'h6E: res.bytes[0] = 8'h0A;
					8'h72: res.bytes[0] = 8'h0D;
					8'h74: res.bytes[0] = 8'h09;
					8'h75: begin
						res.nb = 3'd0;
						mode_d = M_HEX1;
						hex_count_d = 2'd0;
						code_accum_d = '0;
					end
					default: begin
						res.nb = 3'd0;
						res.err = jsu_pkg::E_BAD_ESC;
					end
				endcase
			end
			M_HEX1, M_HEX2: begin
				if (!hx[4]) begin
					res.err = jsu_pkg::E_BAD_HEX;
				end else begin
					code_accum_d = acc_new;
					if (hex_count_q != 2'd3) begin
						hex_count_d = hex_count_q + 2'd1;
					end else begin
						hex_count_d = 2'd0;
						if (mode_q == M_HEX1) begin
							if (acc_new[15:10] == 6'b110110) begin
								high_d = acc_new;
								mode_d = M_NEEDBS;
							end else if (acc_new[15:10] == 6'b110111) begin
								res.err = jsu_pkg::E_LONE_LOW;
							end else begin
								cp = {5'd0, acc_new};
								enc = 1'b1;
								mode_d = M_STR;
							end
						end else begin
							if (acc_new[15:10] != 6'b110111) begin
								res.err = jsu_pkg::E_BAD_LOW;
							end else begin
								// High bits come from the pending high surrogate.
								cp = 21'h10000 + {1'b0, high_q[9:0], acc_new[9:0]};
								enc = 1'b1;
								mode_d = M_STR;
							end
						end
					end
				end
			end
			M_NEEDBS: begin
				if (in_byte == jsu_pkg::CH_BSLASH) mode_d = M_NEEDU;
				else res.err = jsu_pkg::E_MISSING_LOW;
			end
			M_NEEDU: begin
				if (in_byte == 8'h75) begin
					mode_d = M_HEX2;
					hex_count_d = 2'd0;
					code_accum_d = '0;
				end else begin
					res.err = jsu_pkg::E_MISSING_LOW;
				end
			end
			M_HUNT: begin
				if (in_byte == jsu_pkg::CH_QUOTE) mode_d = M_STR;
			end
			default: begin
				if (in_byte == jsu_pkg::CH_QUOTE) mode_d = M_STR;
				else res.err = jsu_pkg::E_NO_OPEN;
			end
		endcase

		if (enc) begin
			res.bytes = utf.bytes;
			res.nb = utf.nb;
		end

		// The byte's own status wins over the end-of-text status.
		if (end_of_text && res.err == jsu_pkg::E_NONE && !res.done) begin
			case (mode_d)
				M_STR:                    res.err = jsu_pkg::E_UNTERM;
				M_ESC:                    res.err = jsu_pkg::E_END_ESC;
				M_HEX1:                   res.err = jsu_pkg::E_SHORT_U;
				M_NEEDBS, M_NEEDU, M_HEX2: res.err = jsu_pkg::E_MISSING_LOW;
				default:                  ;
			endcase
		end

		if (res.err != jsu_pkg::E_NONE) mode_d = end_of_text ? M_START : M_HUNT;
		else if (res.done || end_of_text) mode_d = M_START;
	end

	assign emit = (res.nb != 3'd0) || (res.err != jsu_pkg::E_NONE) || res.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_START;
			hex_count_q  <= '0;
			code_accum_q <= '0;
			high_q       <= '0;
		end else if (step) begin
			mode_q       <= mode_d;
			hex_count_q  <= hex_count_d;
			code_accum_q <= code_accum_d;
			high_q       <= high_d;
		end
	end

endmodule

[hw/rtl/jsu_burst.sv]
// Result register that holds one byte's results and sends them out one item per transfer.
`include "json_string_unescape_utf8_core_assert.svh"

module jsu_burst (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  jsu_pkg::result_t res,
	output logic             free,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             string_done,
	output logic [3:0]       error_code,
	output logic             last
);

	logic            valid_q;
	logic [1:0]      idx_q;
	logic [1:0]      cnt_m1_q;
	logic [3:0][7:0] bytes_q;
	logic [2:0]      nb_q;
	logic            done_q;
	logic [3:0]      err_q;

	assign out_valid   = valid_q;
	assign last        = (idx_q == cnt_m1_q);
	assign byte_valid  = ({1'b0, idx_q} < nb_q);
	assign out_byte    = byte_valid ? bytes_q[idx_q] : 8'h00;
	assign string_done = last && done_q;
	assign error_code  = last ? err_q : 4'(jsu_pkg::E_NONE);
	assign free        = !valid_q || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (valid_q && out_ready) begin
			if (last) valid_q <= 1'b0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	// Payload needs no reset; it is only looked at while valid_q is set.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q  <= res.bytes;
			nb_q     <= res.nb;
			cnt_m1_q <= (res.nb == 3'd0) ? 2'd0 : 2'(res.nb - 3'd1);
			done_q   <= res.done;
			err_q    <= res.err;
		end
	end

	`JSU_ASSERT_NEXT(a_burst_continues, out_valid && out_ready && !last, out_valid && !$stable(idx_q), "burst ended before its last item")
	`JSU_ASSERT_NOW(a_status_only_single, out_valid && !byte_valid, last, "status-only item is not the last one")
	`JSU_ASSERT_NOW(a_status_on_last, out_valid && !last, error_code == 4'(jsu_pkg::E_NONE) && !string_done, "status seen before the last item")
	`JSU_ASSERT_NOW(a_done_no_error, out_valid && string_done, error_code == 4'(jsu_pkg::E_NONE), "string done together with an error")

endmodule
